// File: hw/rtl/mbc_pkg.sv
// Shared types and constants for the Minkowski brightness curve block.
package mbc_pkg;

  localparam int unsigned LEVEL_W       = 17;
  localparam int unsigned CURVE_BITS    = 16;
  // Largest mediant denominator after CURVE_BITS steps is Fibonacci(18) = 2584.
  localparam int unsigned DEN_W         = 12;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic [LEVEL_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [LEVEL_W-1:0] MIN_RESET = 17'd3277;

  typedef struct packed {
    logic [LEVEL_W-1:0]    level;
    logic                  sat;
    logic [DEN_W-1:0]      lo_num;
    logic [DEN_W-1:0]      lo_den;
    logic [DEN_W-1:0]      hi_num;
    logic [DEN_W-1:0]      hi_den;
    logic [CURVE_BITS-1:0] y;
  } walk_t;

endpackage

// File: hw/rtl/minkowski_brightness_curve_core.sv
// Minkowski question-mark brightness curve core, one walk step per pipeline stage.
// Throughput: one request per cycle unless stalled; one pipeline stage per
// Stern-Brocot step, each stage one level-by-denominator multiply and compare,
// then one blend stage.
// Stalls hold only as far back as the first empty stage, so bubbles collapse.
// Reset clears all stage valid bits and sets the floor register min_q to 3277.
module minkowski_brightness_curve_core #(
  parameter int unsigned FRAC_BITS = mbc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mbc_pkg::LEVEL_W-1:0]  level_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mbc_pkg::LEVEL_W-1:0]  brightness_o,
  input  logic                         cfg_we_i,
  input  logic [mbc_pkg::LEVEL_W-1:0]  cfg_wdata_i
);

  localparam int unsigned LW    = mbc_pkg::LEVEL_W;
  localparam int unsigned DW    = mbc_pkg::DEN_W;
  localparam int unsigned NB    = mbc_pkg::CURVE_BITS;
  localparam int unsigned CMP_W = DW + ((FRAC_BITS > LW) ? FRAC_BITS : LW);
  localparam int unsigned NS    = NB + 2;   // input stage, NB walk stages, blend stage

  logic [LW-1:0] min_q;
  logic [LW-1:0] min_clamped;

  logic [NS-1:0] valid_q;
  logic [NS:0]   rdy;

  mbc_pkg::walk_t walk_q [NB+1];
  mbc_pkg::walk_t walk_d [NB+1];

  logic [LW-1:0] bright_q;
  logic [LW-1:0] bright_d;

  // Floor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= mbc_pkg::MIN_RESET;
    end else if (cfg_we_i) begin
      min_q <= cfg_wdata_i;
    end
  end

  assign min_clamped = (min_q > mbc_pkg::ONE_Q16) ? mbc_pkg::ONE_Q16 : min_q;

  // A stage may load when it is empty or its contents move on.
  always_comb begin
    rdy[NS] = ~out_stall_i;
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = ~valid_q[s] | rdy[s+1];
    end
  end

  assign in_stall_o = ~rdy[0];

  // Entry stage: walk bounds start at 0/1 and 1/1
  always_comb begin
    walk_d[0].level  = level_i;
    walk_d[0].sat    = (CMP_W'(level_i) >= (CMP_W'(1) << FRAC_BITS));
    walk_d[0].lo_num = '0;
    walk_d[0].lo_den = DW'(1);
    walk_d[0].hi_num = DW'(1);
    walk_d[0].hi_den = DW'(1);
    walk_d[0].y      = '0;
  end

  // One mediant step per stage
  for (genvar k = 0; k < NB; k++) begin : g_step
    localparam int unsigned BIT = NB - 1 - k;
    logic [DW-1:0]    med_num;
    logic [DW-1:0]    med_den;
    logic [LW+DW-1:0] prod;
    logic [CMP_W-1:0] rhs;
    logic             go_left;

    assign med_num = walk_q[k].lo_num + walk_q[k].hi_num;
    assign med_den = walk_q[k].lo_den + walk_q[k].hi_den;
    assign prod    = {{DW{1'b0}}, walk_q[k].level} * {{LW{1'b0}}, med_den};
    assign rhs     = CMP_W'(med_num) << FRAC_BITS;
    assign go_left = (CMP_W'(prod) < rhs);

    always_comb begin
      walk_d[k+1] = walk_q[k];
      if (go_left) begin
        walk_d[k+1].hi_num = med_num;
        walk_d[k+1].hi_den = med_den;
      end else begin
        walk_d[k+1].lo_num = med_num;
        walk_d[k+1].lo_den = med_den;
        walk_d[k+1].y[BIT] = 1'b1;
      end
    end
  end

  // Blend: (min * 2^16 + (1 - min) * curve + half) >> 16
  logic [LW-1:0]     curve;
  logic [LW-1:0]     span;
  logic [2*LW-1:0]   blend_prod;
  logic [2*LW-1:0]   blend_sum;

  assign curve      = walk_q[NB].sat ? mbc_pkg::ONE_Q16 : {1'b0, walk_q[NB].y};
  assign span       = mbc_pkg::ONE_Q16 - min_clamped;
  assign blend_prod = {{LW{1'b0}}, span} * {{LW{1'b0}}, curve};
  assign blend_sum  = {1'b0, min_clamped, 16'd0} + blend_prod + (2*LW)'(32768);
  assign bright_d   = blend_sum[LW+15:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NS; s++) begin
        if (rdy[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= NB; s++) begin
      if (rdy[s]) begin
        walk_q[s] <= walk_d[s];
      end
    end
    if (rdy[NS-1]) begin
      bright_q <= bright_d;
    end
  end

  assign out_valid_o  = valid_q[NS-1];
  assign brightness_o = bright_q;

endmodule

// File: hw/rtl/mbc_checker.sv
// Port-level checker for the brightness curve core, with its bind.
module mbc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [mbc_pkg::LEVEL_W-1:0]  level_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [mbc_pkg::LEVEL_W-1:0]  brightness_o,
  input logic                         cfg_we_i,
  input logic [mbc_pkg::LEVEL_W-1:0]  cfg_wdata_i
);

  logic [mbc_pkg::LEVEL_W-1:0] floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= mbc_pkg::MIN_RESET;
    end else if (cfg_we_i) begin
      floor_q <= (cfg_wdata_i > mbc_pkg::ONE_Q16) ? mbc_pkg::ONE_Q16 : cfg_wdata_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(brightness_o))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> brightness_o <= mbc_pkg::ONE_Q16)
    else $error("brightness above one");

  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(cfg_we_i) |-> brightness_o >= floor_q)
    else $error("brightness below floor");

  // Input stalls only when the whole pipe is full and the output is held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  logic unused_in;
  assign unused_in = in_valid_i ^ (^level_i);

endmodule

bind minkowski_brightness_curve_core mbc_checker u_mbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .level_i      (level_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .brightness_o (brightness_o),
  .cfg_we_i     (cfg_we_i),
  .cfg_wdata_i  (cfg_wdata_i)
);
